/* hdl/itoa_pkg.sv */
`default_nettype none

package itoa_pkg;

  // One input word: the value to format and the number base.
  typedef struct packed {
    logic signed [63:0] number;
    logic [4:0]         radix;
  } in_t;

  // One output word: a single ASCII character of the string.
  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
  } out_t;

  // Classified job handed from the front to the back through the queue.
  typedef struct packed {
    logic [63:0] magnitude;
    logic [4:0]  radix;
    logic        negative;
  } job_t;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [63:0] MOST_NEG_MAG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {3'd0, d};
    end else begin
      ch = CH_A + {3'd0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* hdl/itoa_ram.sv */
`default_nettype none

module itoa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

/* hdl/itoa_fifo.sv */
`default_nettype none

module itoa_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire itoa_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output itoa_pkg::job_t      pop_data_o
);
  import itoa_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t              mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       fill_q, fill_d;

  assign full_o     = (fill_q == (PW+1)'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + (PW+1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/itoa_front.sv */
`default_nettype none

module itoa_front (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire itoa_pkg::in_t in_word_i,
  output logic               push_o,
  input  wire logic          full_i,
  output itoa_pkg::job_t     job_o
);
  import itoa_pkg::*;

  logic [63:0] raw;
  logic [63:0] negated;

  assign raw     = in_word_i.number;
  assign negated = ~raw + 64'd1;

  // The most negative value has no 64-bit positive twin and saturates.
  always_comb begin
    job_o.negative = raw[63];
    if (raw[63]) begin
      job_o.magnitude = (negated == MOST_NEG_MAG) ? MOST_POS_MAG : negated;
    end else begin
      job_o.magnitude = raw;
    end
    if (in_word_i.radix < RADIX_MIN) begin
      job_o.radix = RADIX_MIN;
    end else if (in_word_i.radix > RADIX_MAX) begin
      job_o.radix = RADIX_MAX;
    end else begin
      job_o.radix = in_word_i.radix;
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

`default_nettype wire

/* hdl/itoa_back.sv */
`default_nettype none

module itoa_back #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  output logic                job_pop_o,
  input  wire itoa_pkg::job_t job_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output itoa_pkg::out_t      out_word_o
);
  import itoa_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS);
  localparam logic [CW-1:0] LastSlot = CW'(MAX_DIGITS - 2);
  localparam logic [CW-1:0] LimitSlot = CW'(MAX_DIGITS - 1);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StDigit,
    StSign,
    StRead,
    StLoad,
    StZero
  } state_e;

  state_e        state_q;
  logic [63:0]   val_q;
  logic [4:0]    radix_q;
  logic          neg_q;
  logic [3:0]    rem_q;
  logic [5:0]    bit_q;
  logic [CW-1:0] dig_q;
  logic          out_valid_q;
  out_t          out_q;

  logic [4:0]    trial;
  logic          fits;
  logic [3:0]    rem_next;
  logic          slot_free;
  logic          emit;
  logic [3:0]    rd_digit;

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial    = {rem_q, val_q[63]};
  assign fits     = (trial >= radix_q);
  assign rem_next = fits ? 4'(trial - radix_q) : trial[3:0];

  assign slot_free = !out_valid_q || !out_stall_i;
  // A new character word is loaded into the output register this cycle.
  assign emit      = slot_free &&
                     (state_q == StSign || state_q == StLoad || state_q == StZero);
  assign job_pop_o = (state_q == StIdle) && job_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  itoa_ram #(
    .WIDTH(4),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i    (clk_i),
    .wr_en_i  (state_q == StDigit),
    .wr_addr_i(dig_q),
    .wr_data_i(rem_q),
    .rd_addr_i(dig_q),
    .rd_data_o(rd_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      val_q       <= '0;
      radix_q     <= RADIX_MIN;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      bit_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            val_q   <= job_i.magnitude;
            radix_q <= job_i.radix;
            neg_q   <= job_i.negative;
            rem_q   <= '0;
            bit_q   <= '0;
            dig_q   <= '0;
            state_q <= (job_i.magnitude == '0) ? StZero : StDiv;
          end
        end
        StDiv: begin
          rem_q <= rem_next;
          val_q <= {val_q[62:0], fits};
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'd63) begin
            state_q <= StDigit;
          end
        end
        StDigit: begin
          // The digit in rem_q is written to the store during this cycle.
          rem_q <= '0;
          bit_q <= '0;
          if (val_q == '0 || dig_q == LastSlot) begin
            state_q <= neg_q ? StSign : StRead;
          end else begin
            dig_q   <= dig_q + CW'(1);
            state_q <= StDiv;
          end
        end
        StSign: begin
          if (slot_free) begin
            out_q.character <= CH_MINUS;
            out_q.last_char <= 1'b0;
            state_q         <= StRead;
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          if (slot_free) begin
            out_q.character <= digit_char(rd_digit);
            out_q.last_char <= (dig_q == '0);
            if (dig_q == '0) begin
              state_q <= StIdle;
            end else begin
              dig_q   <= dig_q - CW'(1);
              state_q <= StRead;
            end
          end
        end
        StZero: begin
          if (slot_free) begin
            out_q.character <= CH_ZERO;
            out_q.last_char <= 1'b1;
            state_q         <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ({1'b0, rem_q} < radix_q))
    else $error("remainder reached the radix during division");

  a_radix_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StDigit) |->
      (radix_q >= RADIX_MIN && radix_q <= RADIX_MAX))
    else $error("radix outside the clamped range");

  a_digit_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) |-> (dig_q != LimitSlot))
    else $error("digit store written at the reserved slot");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.character == CH_MINUS) |-> !out_q.last_char)
    else $error("minus sign flagged as the last character");
`endif

endmodule

`default_nettype wire

/* hdl/signed_integer_to_radix_ascii_core.sv */
`default_nettype none

// Formats a signed 64-bit number as an ASCII string in a base from 2 to 16
// and streams it out one character per output word, most significant digit
// first: a '-' for a negative number, then the digits '0'-'9' and 'A'-'F',
// with last_char set on the final character. Zero yields the single word
// '0', the most negative value is formatted as -(2^63-1), a base below two
// counts as two and a base above sixteen as sixteen. A front stage negates
// and classifies each input word and drops it into a two-entry queue, so up
// to two numbers can be taken while an earlier one is still converting. The
// back end works on one number at a time: once it has picked up a job, a
// bit-serial restoring divider yields one quotient bit per cycle, and each
// digit comes from a full division pass, then its remainder is stored in the
// digit memory. Emission then gives a sign if there is one, and reads each
// digit back through a read state and a load state, as the memory read is
// registered. Output stalls hold up only the emit part, not the division.
// There is no clearing pass after reset.
module signed_integer_to_radix_ascii_core #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire itoa_pkg::in_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output itoa_pkg::out_t     out_word_o
);
  import itoa_pkg::*;

  // Classified jobs cross from the front to the back through this queue.
  job_t front_job;
  job_t back_job;
  logic push;
  logic full;
  logic pop;
  logic empty;

  itoa_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .push_o    (push),
    .full_i    (full),
    .job_o     (front_job)
  );

  itoa_fifo #(
    .DEPTH(2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (back_job)
  );

  // The back end divides, stores the digits and emits the string in reverse.
  itoa_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!empty),
    .job_pop_o  (pop),
    .job_i      (back_job),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

// Self-checking bench for the signed integer to radix ASCII converter.
// Numbers go in one input word at a time. Every accepted word is run
// through a behavioral formatter here, and the characters that it yields
// are queued. Each character word that leaves the block is checked against
// the oldest queued character, both the ASCII code and the last-character
// flag. The sender works in random bursts. The receiver stalls in modes
// that change over the run, so stalls hit every part of the emit phase.
module testbench;
  import itoa_pkg::*;

  localparam int unsigned MAX_DIGITS = 64;
  // One place in the digit store is never written, so at most MAX_DIGITS-1 digits.
  localparam int unsigned DIGIT_LIMIT = MAX_DIGITS - 1;
  localparam int unsigned RANDOM_NUMBERS = 119;
  // A full 63-digit binary string is the longest job for the back end, and
  // up to 64 characters of it may be stalled, with a sender gap on top. The
  // limit allows a wide margin over that for every word of the run.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Quiet time after the last expected character, to catch strays.
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t in_word_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_word_o;

  // Characters still owed by the block, oldest first.
  out_t pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  // Words left in the current sender burst.
  int unsigned burst_left = 0;
  // Receiver stall behavior and how long the current mode lasts.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always #4 clk_i = ~clk_i;

  signed_integer_to_radix_ascii_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Formats one number the way the block should, and queues its characters.
  // The magnitude is divided down to keep the remainders least significant
  // first. They are then queued in reverse, behind a sign if there is one.
  function automatic void format_number(input logic signed [63:0] number,
                                        input logic [4:0] radix);
    logic [63:0] base;
    logic [63:0] magnitude;
    logic [3:0]  digits [MAX_DIGITS];
    logic        negative;
    int          count;
    logic [6:0]  code;
    // Bases outside 2 to 16 are clamped to the nearest end.
    if (radix < RADIX_MIN) begin
      base = 64'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = 64'(RADIX_MAX);
    end else begin
      base = 64'(radix);
    end
    negative  = number[63];
    magnitude = negative ? 64'(-number) : 64'(number);
    // The most negative value has no positive twin, so it saturates.
    if (magnitude == MOST_NEG_MAG) begin
      magnitude = MOST_POS_MAG;
    end
    if (magnitude == 64'd0) begin
      pending_chars.push_back(out_t'{character: CH_ZERO, last_char: 1'b1});
      return;
    end
    count = 0;
    while (magnitude != 64'd0 && count < int'(DIGIT_LIMIT)) begin
      digits[count] = 4'(magnitude % base);
      magnitude     = magnitude / base;
      count++;
    end
    if (negative) begin
      pending_chars.push_back(out_t'{character: CH_MINUS, last_char: 1'b0});
    end
    for (int i = count - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) begin
        code = CH_ZERO + 7'(digits[i]);
      end else begin
        code = CH_A + 7'(digits[i]) - 7'd10;
      end
      pending_chars.push_back(out_t'{character: code, last_char: i == 0});
    end
  endfunction

  // Offers one input word and holds it until the block takes it. Valid stays
  // high into the next word while a burst lasts. Between bursts it may drop for
  // a random gap. The caller is always at a rising edge.
  task automatic send_number(input logic signed [63:0] number,
                             input logic [4:0] radix);
    in_t word;
    int unsigned gap;
    word.number = number;
    word.radix  = radix;
    in_valid_i <= 1'b1;
    in_word_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    format_number(number, radix);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Magnitudes of every width from zero to 64 bits, either sign.
  function automatic logic signed [63:0] random_number();
    logic [63:0] raw;
    int unsigned width;
    raw   = {$urandom, $urandom};
    width = $urandom_range(0, 64);
    if (width < 64) begin
      raw = raw & ((64'd1 << width) - 64'd1);
      if ($urandom_range(0, 1) == 1) begin
        raw = -raw;
      end
    end
    return raw;
  endfunction

  // Mostly legal bases, with some out-of-range ones that must be clamped.
  function automatic logic [4:0] random_radix();
    if ($urandom_range(0, 4) == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return 5'($urandom_range(2, 16));
  endfunction

  task automatic test_zero_and_sign();
    send_number(64'sd0, 5'd10);
    send_number(64'sd0, 5'd2);
    send_number(64'sd1, 5'd10);
    send_number(-64'sd1, 5'd10);
    send_number(-64'sd1, 5'd2);
    send_number(64'sd9, 5'd10);
    send_number(-64'sd10, 5'd10);
    send_number(64'sd15, 5'd16);
    send_number(-64'sd255, 5'd16);
  endtask

  task automatic test_extremes();
    // The longest string is 63 binary digits of the largest magnitude.
    send_number(MOST_POS_MAG, 5'd2);
    send_number(MOST_POS_MAG, 5'd16);
    send_number(-$signed(MOST_POS_MAG), 5'd10);
    // The most negative value must come out as -(2^63-1).
    send_number(MOST_NEG_MAG, 5'd2);
    send_number(MOST_NEG_MAG, 5'd16);
    // Every hex digit from '0' to 'F', with both signs.
    send_number(64'h0123_4567_89AB_CDEF, 5'd16);
    send_number(-64'sh0FED_CBA9_8765_4321, 5'd16);
  endtask

  task automatic test_radix_clamp();
    send_number(64'sd12345, 5'd0);
    send_number(64'sd12345, 5'd1);
    send_number(-64'sd12345, 5'd17);
    send_number(64'sd123456789, 5'd31);
    send_number(64'sd255, 5'd3);
  endtask

  task automatic test_random_numbers();
    for (int i = 0; i < int'(RANDOM_NUMBERS); i++) begin
      send_number(random_number(), random_radix());
    end
  endtask

  task automatic note_mismatch(input string what, input out_t want, input out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("Mismatch at cycle %0d: %s, expected char %h last %b, got char %h last %b",
               cycle_count, what, want.character, want.last_char,
               got.character, got.last_char);
    end
  endtask

  // Each character word that is taken is checked against the oldest one owed.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        note_mismatch("character with none outstanding", '0, out_word_o);
      end else begin
        want = pending_chars.pop_front();
        if (out_word_o.character != want.character ||
            out_word_o.last_char != want.last_char) begin
          note_mismatch("wrong character word", want, out_word_o);
        end
      end
    end
  end

  // The receiver switches between its stall modes: never stalling, stalling
  // now and then, stalling most of the time, and a fixed duty cycle.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= (cycle_count[2:0] >= 3'd5);
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_sign();
    test_extremes();
    test_radix_clamp();
    test_random_numbers();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
